### rtl/core/teq_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// teq_pkg: shared types and constants of the stereo tilt equalizer
// Sample format, coefficient formats, register map and payload types.
// ---------------------------------------------------------------------------
package teq_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS   = 24;
   localparam int COEF_FRAC   = 22;
   localparam int GAIN_BITS   = 24;
   localparam int GAIN_FRAC   = 19;
   localparam int ADDR_BITS   = 5;
   localparam int DATA_BITS   = 32;

   localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(524288);

   typedef enum logic [2:0] {
      REG_MONO_MODE   = 3'd0,
      REG_LP_IN_COEF  = 3'd1,
      REG_LP_FB_COEF  = 3'd2,
      REG_LOW_GAIN    = 3'd3,
      REG_HIGH_GAIN   = 3'd4,
      REG_OUTPUT_GAIN = 3'd5
   } teq_reg_type;

   typedef struct packed {
      logic                         mono_mode;
      logic signed [COEF_BITS-1:0]  lowpass_input_coef;
      logic signed [COEF_BITS-1:0]  lowpass_feedback_coef;
      logic signed [COEF_BITS-1:0]  low_band_gain;
      logic signed [COEF_BITS-1:0]  high_band_gain;
      logic        [GAIN_BITS-1:0]  output_gain;
   } teq_cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_sample;
      logic signed [SAMPLE_BITS-1:0] right_sample;
   } teq_req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } teq_rsp_type;

   typedef struct packed {
      logic                          done;
      logic signed [SAMPLE_BITS-1:0] y;
   } teq_lane_sts_type;

endpackage
`default_nettype wire

### rtl/core/teq_csr.sv
`default_nettype none
// ---------------------------------------------------------------------------
// teq_csr: configuration registers
// APB-style write and read of the six equalizer registers.
// ---------------------------------------------------------------------------
module teq_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [teq_pkg::ADDR_BITS-1:0] csr_paddr,
   input  wire logic [teq_pkg::DATA_BITS-1:0] csr_pwdata,
   output logic      [teq_pkg::DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready,
   output teq_pkg::teq_cfg_type               cfg
);
   import teq_pkg::*;

   teq_cfg_type cfg_ff;
   teq_cfg_type cfg_in;
   teq_reg_type reg_sel;
   logic        wr_en;

   assign reg_sel    = teq_reg_type'(csr_paddr[ADDR_BITS-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_MONO_MODE:   cfg_in.mono_mode             = csr_pwdata[0];
            REG_LP_IN_COEF:  cfg_in.lowpass_input_coef    = csr_pwdata[COEF_BITS-1:0];
            REG_LP_FB_COEF:  cfg_in.lowpass_feedback_coef = csr_pwdata[COEF_BITS-1:0];
            REG_LOW_GAIN:    cfg_in.low_band_gain         = csr_pwdata[COEF_BITS-1:0];
            REG_HIGH_GAIN:   cfg_in.high_band_gain        = csr_pwdata[COEF_BITS-1:0];
            REG_OUTPUT_GAIN: cfg_in.output_gain           = csr_pwdata[GAIN_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_MONO_MODE:   csr_prdata = DATA_BITS'(cfg_ff.mono_mode);
         REG_LP_IN_COEF:  csr_prdata = DATA_BITS'(unsigned'(cfg_ff.lowpass_input_coef));
         REG_LP_FB_COEF:  csr_prdata = DATA_BITS'(unsigned'(cfg_ff.lowpass_feedback_coef));
         REG_LOW_GAIN:    csr_prdata = DATA_BITS'(unsigned'(cfg_ff.low_band_gain));
         REG_HIGH_GAIN:   csr_prdata = DATA_BITS'(unsigned'(cfg_ff.high_band_gain));
         REG_OUTPUT_GAIN: csr_prdata = DATA_BITS'(cfg_ff.output_gain);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mono_mode             <= 1'b0;
         cfg_ff.lowpass_input_coef    <= '0;
         cfg_ff.lowpass_feedback_coef <= '0;
         cfg_ff.low_band_gain         <= '0;
         cfg_ff.high_band_gain        <= '0;
         cfg_ff.output_gain           <= GAIN_UNITY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/teq_lane.sv
`default_nettype none
// ---------------------------------------------------------------------------
// teq_lane: one channel of the tilt equalizer
// Runs the lowpass update, tilt mix and output gain as five multiplies on
// one shared multiplier, and holds its lowpass state and result.
// ---------------------------------------------------------------------------
module teq_lane (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic                                 take,
   input  wire logic signed [teq_pkg::SAMPLE_BITS-1:0] x,
   input  wire teq_pkg::teq_cfg_type                 cfg,
   output teq_pkg::teq_lane_sts_type                 sts
);
   import teq_pkg::*;

   localparam int XW   = SAMPLE_BITS;
   localparam int YW   = XW + 5;
   localparam int AW   = COEF_BITS + 1;
   localparam int PW   = AW + YW;
   localparam int ACCW = PW + 1;
   localparam logic signed [ACCW-1:0] SMAX = {{(ACCW-XW+1){1'b0}}, {(XW-1){1'b1}}};
   localparam logic signed [ACCW-1:0] SMIN = ~SMAX;
   localparam logic signed [ACCW-1:0] HALF_COEF = ACCW'(1) <<< (COEF_FRAC - 1);
   localparam logic signed [ACCW-1:0] HALF_GAIN = ACCW'(1) <<< (GAIN_FRAC - 1);

   typedef enum logic [12:0] {
      S_IDLE = 13'b0000000000001,
      S_P0   = 13'b0000000000010,
      S_P1   = 13'b0000000000100,
      S_ACC1 = 13'b0000000001000,
      S_LP   = 13'b0000000010000,
      S_P2   = 13'b0000000100000,
      S_P3   = 13'b0000001000000,
      S_ACC2 = 13'b0000010000000,
      S_Y    = 13'b0000100000000,
      S_P4   = 13'b0001000000000,
      S_G    = 13'b0010000000000,
      S_OUT  = 13'b0100000000000,
      S_DONE = 13'b1000000000000
   } teq_lane_state_type;

   teq_lane_state_type       state_ff, state_in;
   logic signed [XW-1:0]     x_ff, x_in;
   logic signed [XW-1:0]     lp_ff, lp_in;
   logic signed [YW-1:0]     y_ff, y_in;
   logic signed [XW-1:0]     out_ff, out_in;
   logic signed [PW-1:0]     prod_ff, prod_in;
   logic signed [ACCW-1:0]   acc_ff, acc_in;
   logic signed [AW-1:0]     mul_a;
   logic signed [YW-1:0]     mul_b;
   logic signed [XW:0]       diff;
   logic signed [ACCW-1:0]   prod_ext;
   logic signed [ACCW-1:0]   coef_rnd;
   logic signed [ACCW-1:0]   gain_rnd;
   logic signed [XW-1:0]     lp_sat;
   logic signed [XW-1:0]     out_sat;

   assign diff     = {x_ff[XW-1], x_ff} - {lp_ff[XW-1], lp_ff};
   assign prod_ext = {prod_ff[PW-1], prod_ff};
   assign coef_rnd = (acc_ff + HALF_COEF) >>> COEF_FRAC;
   assign gain_rnd = (acc_ff + HALF_GAIN) >>> GAIN_FRAC;

   always_comb begin
      if (coef_rnd > SMAX) begin
         lp_sat = SMAX[XW-1:0];
      end else if (coef_rnd < SMIN) begin
         lp_sat = SMIN[XW-1:0];
      end else begin
         lp_sat = coef_rnd[XW-1:0];
      end
      if (gain_rnd > SMAX) begin
         out_sat = SMAX[XW-1:0];
      end else if (gain_rnd < SMIN) begin
         out_sat = SMIN[XW-1:0];
      end else begin
         out_sat = gain_rnd[XW-1:0];
      end
   end

   always_comb begin
      unique case (state_ff)
         S_P0: begin
            mul_a = AW'(cfg.lowpass_input_coef);
            mul_b = YW'(x_ff);
         end
         S_P1: begin
            mul_a = AW'(cfg.lowpass_feedback_coef);
            mul_b = YW'(lp_ff);
         end
         S_P2: begin
            mul_a = AW'(cfg.low_band_gain);
            mul_b = YW'(lp_ff);
         end
         S_P3: begin
            mul_a = AW'(cfg.high_band_gain);
            mul_b = YW'(diff);
         end
         S_P4: begin
            mul_a = {1'b0, cfg.output_gain};
            mul_b = y_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      lp_in    = lp_ff;
      y_in     = y_ff;
      out_in   = out_ff;
      acc_in   = acc_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               x_in     = x;
               state_in = S_P0;
            end
         end
         S_P0: state_in = S_P1;
         S_P1: begin
            acc_in   = prod_ext;
            state_in = S_ACC1;
         end
         S_ACC1: begin
            acc_in   = acc_ff + prod_ext;
            state_in = S_LP;
         end
         S_LP: begin
            lp_in    = lp_sat;
            state_in = S_P2;
         end
         S_P2: state_in = S_P3;
         S_P3: begin
            acc_in   = prod_ext;
            state_in = S_ACC2;
         end
         S_ACC2: begin
            acc_in   = acc_ff + prod_ext;
            state_in = S_Y;
         end
         S_Y: begin
            y_in     = coef_rnd[YW-1:0] + {{(YW-XW){x_ff[XW-1]}}, x_ff};
            state_in = S_P4;
         end
         S_P4: state_in = S_G;
         S_G: begin
            acc_in   = prod_ext;
            state_in = S_OUT;
         end
         S_OUT: begin
            out_in   = out_sat;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         lp_ff    <= lp_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      out_ff  <= out_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign sts.done = (state_ff == S_DONE);
   assign sts.y    = out_ff;

`ifndef SYNTHESIS
   a_lp_only_in_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LP) |=> $stable(lp_ff))
      else $error("lowpass state changed outside its update step");
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == S_IDLE))
      else $error("lane started while busy");
   a_take_when_done: assert property (@(posedge clock) disable iff (reset)
      take |-> (state_ff == S_DONE))
      else $error("lane result taken before it was done");
   a_done_follows_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |=> (state_ff == S_DONE))
      else $error("lane skipped its done state");
`endif

endmodule
`default_nettype wire

### rtl/core/teq_merge.sv
`default_nettype none
// ---------------------------------------------------------------------------
// teq_merge: result merge and output register
// Combines the lane results into one stereo beat and holds it until taken.
// ---------------------------------------------------------------------------
module teq_merge (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      mono_mode,
   input  wire teq_pkg::teq_lane_sts_type left_sts,
   input  wire teq_pkg::teq_lane_sts_type right_sts,
   input  wire logic                      rsp_stall,
   output logic                           rsp_valid,
   output teq_pkg::teq_rsp_type           rsp_data,
   output logic                           take_left,
   output logic                           take_right
);
   import teq_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   teq_rsp_type rsp_data_ff, rsp_data_in;
   logic        ready;
   logic        load;

   assign ready = left_sts.done & (mono_mode | right_sts.done);
   assign load  = ready & (~rsp_valid_ff | ~rsp_stall);

   assign take_left  = load;
   assign take_right = load & ~mono_mode;

   always_comb begin
      rsp_valid_in = load | (rsp_valid_ff & rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_data_in.left_out  = left_sts.y;
         rsp_data_in.right_out = mono_mode ? left_sts.y : right_sts.y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

### rtl/core/tilt_equalizer_stereo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tilt_equalizer_stereo: stereo one-pole tilt equalizer
// A stereo pair is accepted, each channel runs in its own lane, and the
// merged pair leaves through a registered output beat.
// ---------------------------------------------------------------------------
// A new stereo pair is taken only after the previous result has been
// moved into the output register. Each lane runs its sequence of five
// multiplies on its single multiplier with a registered product. The
// output register lets the next pair enter while a result still waits to
// be taken. In mono mode the left lane processes the floor average of both
// inputs, the right lowpass state holds, and both outputs carry the same
// value. Write registers only while the block is idle.
module tilt_equalizer_stereo (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire teq_pkg::teq_req_type          req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output teq_pkg::teq_rsp_type               rsp_data,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [teq_pkg::ADDR_BITS-1:0] csr_paddr,
   input  wire logic [teq_pkg::DATA_BITS-1:0] csr_pwdata,
   output logic      [teq_pkg::DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);
   import teq_pkg::*;

   teq_cfg_type             cfg;
   teq_lane_sts_type        left_sts, right_sts;
   logic                    busy_ff, busy_in;
   logic                    accept;
   logic                    take_left, take_right;
   logic signed [SAMPLE_BITS:0]   pair_sum;
   logic signed [SAMPLE_BITS-1:0] left_x;

   assign req_stall = busy_ff;
   assign accept    = req_valid & ~busy_ff;
   assign busy_in   = accept | (busy_ff & ~take_left);

   assign pair_sum = {req_data.left_sample[SAMPLE_BITS-1], req_data.left_sample}
                   + {req_data.right_sample[SAMPLE_BITS-1], req_data.right_sample};
   assign left_x   = cfg.mono_mode ? pair_sum[SAMPLE_BITS:1] : req_data.left_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   teq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   teq_lane u_lane_left (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .take  (take_left),
      .x     (left_x),
      .cfg   (cfg),
      .sts   (left_sts)
   );

   teq_lane u_lane_right (
      .clock (clock),
      .reset (reset),
      .start (accept & ~cfg.mono_mode),
      .take  (take_right),
      .x     (req_data.right_sample),
      .cfg   (cfg),
      .sts   (right_sts)
   );

   teq_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .mono_mode  (cfg.mono_mode),
      .left_sts   (left_sts),
      .right_sts  (right_sts),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .take_left  (take_left),
      .take_right (take_right)
   );

endmodule
`default_nettype wire

### tb/tilt_equalizer_stereo_tb.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tilt_equalizer_stereo_tb: self-checking bench of the stereo tilt equalizer
// Drives stereo pairs through the valid/stall input channel and writes the
// register file over the APB-style port while the block is idle. A model of
// the one-pole lowpass and tilt arithmetic predicts every output beat, which
// is compared field by field in arrival order. A directed table covers reset
// behavior, sample extremes, mono averaging, held right state and saturating
// settings; random phases with random settings and idling follow.
// ---------------------------------------------------------------------------
module tilt_equalizer_stereo_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import teq_pkg::*;

   localparam int SAMPLE_MAX     = 2 ** (SAMPLE_BITS - 1) - 1;
   localparam int SAMPLE_MIN     = -(2 ** (SAMPLE_BITS - 1));
   localparam int REG_SLOTS      = 2 ** (ADDR_BITS - 2);
   localparam int IDLE_PERCENT   = 31;
   localparam int DIR_ROWS       = 25;
   localparam int DIR_SETTINGS   = 7;
   localparam int RAND_PHASES    = 7;
   localparam int PHASE_PAIRS    = 100;
   localparam int QUIET_PHASE    = 2;
   localparam int SETTLE_CYCLES  = 30;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct {
      int setting;
      bit known;
      int left;
      int right;
      int left_want;
      int right_want;
   } directed_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   teq_req_type            req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   teq_rsp_type            rsp_data;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [ADDR_BITS-1:0]   csr_paddr;
   logic [DATA_BITS-1:0]   csr_pwdata;
   logic [DATA_BITS-1:0]   csr_prdata;
   logic                   csr_pready;

   teq_cfg_type                   shadow_cfg;
   logic signed [SAMPLE_BITS-1:0] left_lp;
   logic signed [SAMPLE_BITS-1:0] right_lp;
   teq_rsp_type                   expected_pairs [$];
   bit                            typed_valid;
   teq_rsp_type                   typed_pair;
   bit                            no_idle;
   int                            mismatches;
   int                            idle_cycles;

   teq_cfg_type dir_settings [DIR_SETTINGS] = '{
      '{1'b0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, GAIN_UNITY},
      '{1'b1, 24'sd0, 24'sd0, 24'sd0, 24'sd0, GAIN_UNITY},
      '{1'b0, 24'sd1048576, 24'sd3145728, 24'sd2097152, 24'sd4194304, 24'd0},
      '{1'b0, 24'sd524288, 24'sd3670016, 24'sd4194304, -24'sd2097152, GAIN_UNITY},
      '{1'b1, 24'sd524288, 24'sd3670016, 24'sd4194304, -24'sd2097152, GAIN_UNITY},
      '{1'b0, 24'sd524288, 24'sd3670016, 24'sd4194304, -24'sd2097152, GAIN_UNITY},
      '{1'b0, 24'sd8388607, -24'sd8388608, -24'sd8388608, 24'sd8388607, 24'hFFFFFF}
   };

   directed_row_type dir_rows [DIR_ROWS] = '{
      '{0, 1, 0, 0, 0, 0},
      '{0, 1, 8388607, -8388608, 8388607, -8388608},
      '{0, 1, -8388608, 8388607, -8388608, 8388607},
      '{0, 1, -1, 1, -1, 1},
      '{0, 1, 5592405, -5592406, 5592405, -5592406},
      '{1, 1, -1, 0, -1, -1},
      '{1, 1, 8388607, 8388607, 8388607, 8388607},
      '{1, 1, -8388608, -8388608, -8388608, -8388608},
      '{1, 1, 3, -6, -2, -2},
      '{1, 1, 8388607, -8388608, -1, -1},
      '{2, 1, 8388607, -8388608, 0, 0},
      '{2, 1, 1000, -1000, 0, 0},
      '{3, 0, 8388607, -8388608, 0, 0},
      '{3, 0, 8388607, -8388608, 0, 0},
      '{3, 0, -8388608, 8388607, 0, 0},
      '{3, 0, 0, 0, 0, 0},
      '{3, 0, 12345, -54321, 0, 0},
      '{4, 0, 4000000, 2000000, 0, 0},
      '{4, 0, -8388608, -8388608, 0, 0},
      '{4, 0, 1, 2, 0, 0},
      '{5, 0, 0, 0, 0, 0},
      '{5, 0, 100000, 100000, 0, 0},
      '{6, 0, 8388607, -8388608, 0, 0},
      '{6, 0, -8388608, 8388607, 0, 0},
      '{6, 0, -1, 1, 0, 0}
   };

   tilt_equalizer_stereo uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint round_q(input longint v, input int frac);
      return (v + (longint'(1) <<< (frac - 1))) >>> frac;
   endfunction

   function automatic longint clamp_sample(input longint v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      return v;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] tilt_channel(
      input longint x, inout logic signed [SAMPLE_BITS-1:0] lp);
      longint acc;
      longint lp_new;
      longint tilt;
      longint y;
      acc = longint'(shadow_cfg.lowpass_input_coef) * x
          + longint'(shadow_cfg.lowpass_feedback_coef) * longint'(lp);
      lp_new = clamp_sample(round_q(acc, COEF_FRAC));
      lp = SAMPLE_BITS'(lp_new);
      tilt = longint'(shadow_cfg.low_band_gain) * lp_new
           + longint'(shadow_cfg.high_band_gain) * (x - lp_new);
      y = x + round_q(tilt, COEF_FRAC);
      return SAMPLE_BITS'(clamp_sample(round_q(y * longint'({1'b0, shadow_cfg.output_gain}),
                                               GAIN_FRAC)));
   endfunction

   function automatic teq_rsp_type predict_pair(input teq_req_type d);
      teq_rsp_type r;
      longint avg;
      if (shadow_cfg.mono_mode) begin
         avg = (longint'(d.left_sample) + longint'(d.right_sample)) >>> 1;
         r.left_out  = tilt_channel(avg, left_lp);
         r.right_out = r.left_out;
      end else begin
         r.left_out  = tilt_channel(longint'(d.left_sample), left_lp);
         r.right_out = tilt_channel(longint'(d.right_sample), right_lp);
      end
      return r;
   endfunction

   function automatic logic [DATA_BITS-1:0] pad_upper(input logic [DATA_BITS-1:0] v,
                                                      input int bits);
      logic [DATA_BITS-1:0] mask;
      mask = (DATA_BITS'(1) << bits) - 1;
      return (DATA_BITS'($urandom()) & ~mask) | (v & mask);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(0, 19))
         0: return SAMPLE_BITS'(SAMPLE_MAX);
         1: return SAMPLE_BITS'(SAMPLE_MIN);
         2: return '0;
         3: return '1;
         default: return SAMPLE_BITS'($urandom());
      endcase
   endfunction

   function automatic teq_cfg_type random_setting();
      teq_cfg_type s;
      int a0;
      s.mono_mode = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) begin
         s.lowpass_input_coef    = COEF_BITS'($urandom());
         s.lowpass_feedback_coef = COEF_BITS'($urandom());
         s.low_band_gain         = COEF_BITS'($urandom());
         s.high_band_gain        = COEF_BITS'($urandom());
      end else begin
         a0 = $urandom_range(0, 2 ** COEF_FRAC);
         s.lowpass_input_coef    = COEF_BITS'(a0);
         s.lowpass_feedback_coef = COEF_BITS'(2 ** COEF_FRAC - a0);
         s.low_band_gain         = COEF_BITS'($urandom_range(0, 8126464) - 3932160);
         s.high_band_gain        = COEF_BITS'($urandom_range(0, 8126464) - 3932160);
      end
      if ($urandom_range(0, 9) == 0) s.output_gain = GAIN_BITS'($urandom());
      else s.output_gain = GAIN_BITS'($urandom_range(0, 2 ** (GAIN_FRAC + 2)));
      return s;
   endfunction

   function automatic int idle_gap();
      int gap;
      gap = 0;
      while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) gap++;
      return gap;
   endfunction

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [DATA_BITS-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_MONO_MODE:   shadow_cfg.mono_mode             = data[0];
         REG_LP_IN_COEF:  shadow_cfg.lowpass_input_coef    = data[COEF_BITS-1:0];
         REG_LP_FB_COEF:  shadow_cfg.lowpass_feedback_coef = data[COEF_BITS-1:0];
         REG_LOW_GAIN:    shadow_cfg.low_band_gain         = data[COEF_BITS-1:0];
         REG_HIGH_GAIN:   shadow_cfg.high_band_gain        = data[COEF_BITS-1:0];
         REG_OUTPUT_GAIN: shadow_cfg.output_gain           = data[GAIN_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pairs.size() != 0) @(posedge clock);
   endtask

   task automatic apply_setting(input teq_cfg_type s);
      wait_results();
      csr_write(REG_MONO_MODE,   pad_upper(DATA_BITS'(s.mono_mode), 1));
      csr_write(REG_LP_IN_COEF,  pad_upper(DATA_BITS'(s.lowpass_input_coef), COEF_BITS));
      csr_write(REG_LP_FB_COEF,  pad_upper(DATA_BITS'(s.lowpass_feedback_coef), COEF_BITS));
      csr_write(REG_LOW_GAIN,    pad_upper(DATA_BITS'(s.low_band_gain), COEF_BITS));
      csr_write(REG_HIGH_GAIN,   pad_upper(DATA_BITS'(s.high_band_gain), COEF_BITS));
      csr_write(REG_OUTPUT_GAIN, pad_upper(DATA_BITS'(s.output_gain), GAIN_BITS));
      for (int i = int'(REG_OUTPUT_GAIN) + 1; i < REG_SLOTS; i++)
         csr_write(3'(i), DATA_BITS'($urandom()));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_pair(input teq_req_type d, input bit known, input teq_rsp_type want);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_data    <= d;
      typed_valid = known;
      typed_pair  = want;
      do @(posedge clock); while (req_stall);
   endtask

   always @(negedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   always @(posedge clock) begin
      teq_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pairs.size() == 0) begin
               report($sformatf("unexpected beat left_out=%0d right_out=%0d",
                                rsp_data.left_out, rsp_data.right_out));
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_data.left_out !== want.left_out)
                  report($sformatf("left_out expected %0d, got %0d",
                                   want.left_out, rsp_data.left_out));
               if (rsp_data.right_out !== want.right_out)
                  report($sformatf("right_out expected %0d, got %0d",
                                   want.right_out, rsp_data.right_out));
            end
         end
         if (req_valid && !req_stall) begin
            want = predict_pair(req_data);
            if (typed_valid) want = typed_pair;
            expected_pairs.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int          cur_set;
      teq_req_type d;
      teq_rsp_type want;
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      shadow_cfg  = dir_settings[0];
      left_lp     = '0;
      right_lp    = '0;
      typed_valid = 1'b0;
      typed_pair  = '0;
      no_idle     = 1'b0;
      mismatches  = 0;
      idle_cycles = 0;
      cur_set     = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].setting != cur_set) begin
            cur_set = dir_rows[i].setting;
            apply_setting(dir_settings[cur_set]);
         end
         d.left_sample   = SAMPLE_BITS'(dir_rows[i].left);
         d.right_sample  = SAMPLE_BITS'(dir_rows[i].right);
         want.left_out   = SAMPLE_BITS'(dir_rows[i].left_want);
         want.right_out  = SAMPLE_BITS'(dir_rows[i].right_want);
         send_pair(d, dir_rows[i].known, want);
      end

      for (int p = 0; p < RAND_PHASES; p++) begin
         apply_setting(random_setting());
         no_idle = (p == QUIET_PHASE);
         for (int i = 0; i < PHASE_PAIRS; i++) begin
            if ($urandom_range(0, 49) == 0) wait_results();
            d.left_sample  = random_sample();
            d.right_sample = random_sample();
            send_pair(d, 1'b0, '0);
         end
      end

      no_idle = 1'b0;
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_pairs.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire
